/* src/wormhole_xy_mesh_router_macros.svh */
// ----------------------------------------------------------------------------
// wormhole xy mesh router assertion macros
// shared concurrent assertion forms, clocked on clk with active-low reset
// ----------------------------------------------------------------------------
`ifndef WORMHOLE_XY_MESH_ROUTER_MACROS_SVH
`define WORMHOLE_XY_MESH_ROUTER_MACROS_SVH

// same-cycle implication
`define WXY_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wxy assertion failed");

// next-cycle implication
`define WXY_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wxy assertion failed");

`endif

/* src/wxy_pkg.sv */
// ----------------------------------------------------------------------------
// wxy_pkg
// types, constants and the xy route function of the mesh router
// ----------------------------------------------------------------------------
package wxy_pkg;

    localparam int NUM_PORTS = 6;
    localparam int PORT_W    = 3;
    localparam int FLIT_W    = 34;
    localparam int ID_W      = 4;
    localparam int MESH_COLS = 4;
    localparam int COL_W     = $clog2(MESH_COLS);

    // flit field positions
    localparam int FKIND_LSB = 32;
    localparam int DEST_LSB  = 28;
    localparam int TYPE_LSB  = 24;

    localparam logic [1:0]      FKIND_HEAD        = 2'd0;
    localparam logic [1:0]      FKIND_TAIL        = 2'd2;
    localparam logic [ID_W-1:0] PTYPE_NODE_RESULT = 4'd4;

    typedef enum logic
    {
        KIND_ARRIVAL = 1'b0,
        KIND_TICK    = 1'b1
    } item_kind_t;

    typedef enum logic [PORT_W-1:0]
    {
        PORT_LOCAL = 3'd0,
        PORT_NORTH = 3'd1,
        PORT_EAST  = 3'd2,
        PORT_SOUTH = 3'd3,
        PORT_WEST  = 3'd4,
        PORT_CTRL  = 3'd5
    } port_t;

    typedef struct packed
    {
        logic empty;
        logic full;
    } fifo_status_t;

    typedef struct packed
    {
        logic              sent;
        logic [PORT_W-1:0] port;
        logic [FLIT_W-1:0] flit;
    } fwd_t;

    function automatic port_t route_head(input logic [ID_W-1:0] id,
                                         input logic [FLIT_W-1:0] flit);
        logic [ID_W-1:0]       dest;
        logic [ID_W-1:0]       ptype;
        logic [COL_W-1:0]      cx;
        logic [COL_W-1:0]      dx;
        logic [ID_W-COL_W-1:0] cy;
        logic [ID_W-COL_W-1:0] dy;
        port_t                 r;
        dest  = flit[DEST_LSB +: ID_W];
        ptype = flit[TYPE_LSB +: ID_W];
        cx    = id[COL_W-1:0];
        cy    = id[ID_W-1:COL_W];
        dx    = dest[COL_W-1:0];
        dy    = dest[ID_W-1:COL_W];
        if (id == '0 && dest == '0 && ptype == PTYPE_NODE_RESULT)
            r = PORT_CTRL;
        else if (dest == id)
            r = PORT_LOCAL;
        else if (dx > cx)
            r = PORT_EAST;
        else if (dx < cx)
            r = PORT_WEST;
        else if (dy > cy)
            r = PORT_SOUTH;
        else if (dy < cy)
            r = PORT_NORTH;
        else
            r = PORT_LOCAL;
        return r;
    endfunction

endpackage

/* src/wxy_req_if.sv */
// ----------------------------------------------------------------------------
// wxy_req_if
// request channel: flit arrivals and transmit ticks
// ----------------------------------------------------------------------------
interface wxy_req_if;
    import wxy_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [2:0]        arrival_port;
    logic [FLIT_W-1:0] arriving_flit;

    modport source (output valid, kind, arrival_port, arriving_flit, input ready);
    modport sink   (input valid, kind, arrival_port, arriving_flit, output ready);
endinterface

/* src/wxy_rsp_if.sv */
// ----------------------------------------------------------------------------
// wxy_rsp_if
// response channel: store status and forwarded flit
// ----------------------------------------------------------------------------
interface wxy_rsp_if;
    import wxy_pkg::*;

    logic              valid;
    logic              ready;
    logic              accepted;
    logic              sent;
    logic [2:0]        send_port;
    logic [FLIT_W-1:0] sent_flit;

    modport source (output valid, accepted, sent, send_port, sent_flit, input ready);
    modport sink   (input valid, accepted, sent, send_port, sent_flit, output ready);
endinterface

/* src/wxy_ram.sv */
// ----------------------------------------------------------------------------
// wxy_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module wxy_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

/* src/wxy_fifo.sv */
// ----------------------------------------------------------------------------
// wxy_fifo
// per-port flit fifo with show-ahead front built on a registered-read ram
// ----------------------------------------------------------------------------
module wxy_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [wxy_pkg::FLIT_W-1:0] push_data,
    input  logic                      pop,
    output logic [wxy_pkg::FLIT_W-1:0] front,
    output wxy_pkg::fifo_status_t     status
);
    import wxy_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              byp_reg, byp_next;
    logic [FLIT_W-1:0] byp_data_reg;
    logic [FLIT_W-1:0] ram_rdata;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_next - 1'b1;
        end
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_next + 1'b1;
        end
        // ram read of the same entry being written returns stale data
        byp_next = push && (wr_ptr_reg == rd_ptr_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
            byp_reg    <= 1'b0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            byp_reg    <= byp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byp_next)
            byp_data_reg <= push_data;
    end

    wxy_ram #(
        .WIDTH (FLIT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (push),
        .waddr (wr_ptr_reg),
        .wdata (push_data),
        .raddr (rd_ptr_next),
        .rdata (ram_rdata)
    );

    assign front        = byp_reg ? byp_data_reg : ram_rdata;
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));

endmodule

/* src/wxy_switch.sv */
// ----------------------------------------------------------------------------
// wxy_switch
// output locks, locked-first scan and head-flit xy allocation
// ----------------------------------------------------------------------------
module wxy_switch (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      tick,
    input  logic [wxy_pkg::ID_W-1:0]  router_id,
    input  logic [wxy_pkg::FLIT_W-1:0] front [wxy_pkg::NUM_PORTS],
    input  logic [wxy_pkg::NUM_PORTS-1:0] nonempty,
    output logic [wxy_pkg::NUM_PORTS-1:0] pop,
    output wxy_pkg::fwd_t             fwd
);
    import wxy_pkg::*;

    logic [NUM_PORTS-1:0] locked_reg, locked_next;
    logic [PORT_W-1:0]    owner_reg [NUM_PORTS];
    logic [PORT_W-1:0]    owner_next [NUM_PORTS];
    logic [NUM_PORTS-1:0] lock_cand;
    logic [NUM_PORTS-1:0] head_cand;
    port_t                route [NUM_PORTS];
    logic [PORT_W-1:0]    lock_sel;
    logic [PORT_W-1:0]    head_sel;
    logic [PORT_W-1:0]    src;

    always_comb
    begin
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            route[p]     = route_head(router_id, front[p]);
            head_cand[p] = nonempty[p] && (front[p][FKIND_LSB +: 2] == FKIND_HEAD)
                           && !locked_reg[route[p]];
            lock_cand[p] = locked_reg[p] && nonempty[owner_reg[p]];
        end
    end

    // priority pick, lowest port wins
    always_comb
    begin
        lock_sel = '0;
        head_sel = '0;
        for (int i = NUM_PORTS - 1; i >= 0; i--)
        begin
            if (lock_cand[i])
                lock_sel = PORT_W'(i);
            if (head_cand[i])
                head_sel = PORT_W'(i);
        end
    end

    assign src = owner_reg[lock_sel];

    always_comb
    begin
        locked_next = locked_reg;
        owner_next  = owner_reg;
        pop         = '0;
        fwd         = '0;
        if (tick)
        begin
            if (|lock_cand)
            begin
                pop[src]  = 1'b1;
                fwd.sent  = 1'b1;
                fwd.port  = lock_sel;
                fwd.flit  = front[src];
                // tail closes the wormhole
                if (front[src][FKIND_LSB +: 2] == FKIND_TAIL)
                begin
                    locked_next[lock_sel] = 1'b0;
                    owner_next[lock_sel]  = '0;
                end
            end
            else if (|head_cand)
            begin
                locked_next[route[head_sel]] = 1'b1;
                owner_next[route[head_sel]]  = head_sel;
                pop[head_sel] = 1'b1;
                fwd.sent      = 1'b1;
                fwd.port      = route[head_sel];
                fwd.flit      = front[head_sel];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg <= '0;
            for (int o = 0; o < NUM_PORTS; o++)
                owner_reg[o] <= '0;
        end
        else
        begin
            locked_reg <= locked_next;
            owner_reg  <= owner_next;
        end
    end

endmodule

/* src/wormhole_xy_mesh_router.sv */
// the response is registered: a request passes the input register, then the result register
// throughput: one request per cycle while the response is not stalled, the six fifo fronts are held ready every cycle
// a stalled response blocks at most one request in the input register
// reset: fifo pointers, counts, output locks, owners and router_id clear; no clearing pass,
// fifo storage holds no reset and is read only after it is written
// ----------------------------------------------------------------------------
// wormhole_xy_mesh_router
// six-port wormhole router with per-port flit fifos and xy routing on a mesh
// ----------------------------------------------------------------------------
module wormhole_xy_mesh_router #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [wxy_pkg::ID_W-1:0] cfg_wr_data,
    wxy_req_if.sink                  req,
    wxy_rsp_if.source                rsp
);
    import wxy_pkg::*;

    logic                 in_valid_reg;
    logic                 kind_reg;
    logic [2:0]           port_reg;
    logic [FLIT_W-1:0]    flit_reg;
    logic                 res_valid_reg, res_valid_next;
    logic                 accepted_reg;
    fwd_t                 fwd_reg;
    logic [ID_W-1:0]      router_id_reg;

    logic                 proc;
    logic                 tick;
    logic [NUM_PORTS-1:0] push;
    logic [NUM_PORTS-1:0] pop;
    logic [NUM_PORTS-1:0] nonempty;
    logic [FLIT_W-1:0]    front [NUM_PORTS];
    fifo_status_t         status [NUM_PORTS];
    fwd_t                 fwd;

    assign proc      = in_valid_reg && (!res_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || proc;
    assign tick      = proc && (kind_reg == KIND_TICK);

    always_comb
    begin
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            push[p]     = proc && (kind_reg == KIND_ARRIVAL) && (port_reg == PORT_W'(p))
                          && !status[p].full;
            nonempty[p] = !status[p].empty;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_PORTS; g++)
        begin : gen_fifo
            wxy_fifo #(
                .DEPTH (FIFO_DEPTH)
            ) u_fifo (
                .clk       (clk),
                .rst_n     (rst_n),
                .push      (push[g]),
                .push_data (flit_reg),
                .pop       (pop[g]),
                .front     (front[g]),
                .status    (status[g])
            );
        end
    endgenerate

    wxy_switch u_switch (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .router_id (router_id_reg),
        .front     (front),
        .nonempty  (nonempty),
        .pop       (pop),
        .fwd       (fwd)
    );

    always_comb
    begin
        if (proc)
            res_valid_next = 1'b1;
        else if (rsp.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            router_id_reg <= '0;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            res_valid_reg <= res_valid_next;
            if (cfg_wr_en)
                router_id_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            kind_reg <= req.kind;
            port_reg <= req.arrival_port;
            flit_reg <= req.arriving_flit;
        end
        if (proc)
        begin
            accepted_reg <= |push;
            fwd_reg      <= fwd;
        end
    end

    assign rsp.valid     = res_valid_reg;
    assign rsp.accepted  = accepted_reg;
    assign rsp.sent      = fwd_reg.sent;
    assign rsp.send_port = fwd_reg.port;
    assign rsp.sent_flit = fwd_reg.flit;

endmodule

/* src/wxy_checker.sv */
// ----------------------------------------------------------------------------
// wxy_checker
// port-level checks of the mesh router, bound to the top level
// ----------------------------------------------------------------------------
`include "wormhole_xy_mesh_router_macros.svh"

module wxy_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic                      req_ready,
    input  logic                      rsp_valid,
    input  logic                      rsp_ready,
    input  logic                      rsp_accepted,
    input  logic                      rsp_sent,
    input  logic [2:0]                rsp_send_port,
    input  logic [wxy_pkg::FLIT_W-1:0] rsp_sent_flit
);
    import wxy_pkg::*;

    // a stalled response holds its flit
    `WXY_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sent_flit))

    // a transaction stores or forwards, never both
    `WXY_ASSERT_IMP(a_excl, rsp_valid, !(rsp_accepted && rsp_sent))

    // nothing forwarded means zero port and flit
    `WXY_ASSERT_IMP(a_idle_zero, rsp_valid && !rsp_sent,
                    rsp_send_port == 3'd0 && rsp_sent_flit == '0)

    // forwarded port is a real port
    `WXY_ASSERT_IMP(a_port_range, rsp_valid && rsp_sent,
                    rsp_send_port != 3'd6 && rsp_send_port != 3'd7)

    // a taken request reaches a valid response through the input and result registers when the response side is open
    `WXY_ASSERT_NXT(a_latency, req_valid && req_ready ##1 rsp_ready, rsp_valid)

endmodule

bind wormhole_xy_mesh_router wxy_checker u_wxy_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_accepted  (rsp.accepted),
    .rsp_sent      (rsp.sent),
    .rsp_send_port (rsp.send_port),
    .rsp_sent_flit (rsp.sent_flit)
);

/* tb/wormhole_xy_mesh_router_test.sv */
// ----------------------------------------------------------------------------
// wormhole_xy_mesh_router_test
// drives flit arrivals and transmit ticks into the router while a scoreboard
// model of the six input fifos, the output locks and xy routing predicts every
// response; a directed opening is followed by well-formed packet traffic under
// several router ids and a closing phase with broken packets and dropped flits
// ----------------------------------------------------------------------------
module wormhole_xy_mesh_router_test;
    import wxy_pkg::*;

    localparam int FIFO_DEPTH  = 16;
    localparam int IDLE_PCT    = 18;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 220;

    localparam logic [1:0] FKIND_BODY = 2'd1;
    localparam logic [1:0] FKIND_RSVD = 2'd3;

    typedef struct packed
    {
        logic              kind;
        logic [PORT_W-1:0] port;
        logic [FLIT_W-1:0] flit;
    } router_req_t;

    typedef struct packed
    {
        logic              accepted;
        logic              sent;
        logic [PORT_W-1:0] port;
        logic [FLIT_W-1:0] flit;
    } router_rsp_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [ID_W-1:0]     cfg_wr_data;

    wxy_req_if req_ch ();
    wxy_rsp_if rsp_ch ();

    wormhole_xy_mesh_router #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // scoreboard copy of the router state
    logic [FLIT_W-1:0] fifo_mem [NUM_PORTS][FIFO_DEPTH];
    int                fifo_rd [NUM_PORTS];
    int                fifo_wr [NUM_PORTS];
    int                fifo_cnt [NUM_PORTS];
    bit                out_locked [NUM_PORTS];
    int                out_owner [NUM_PORTS];
    logic [ID_W-1:0]   node_id;

    // packet generator: flits still to come in the open packet of each port
    int                pkt_left [NUM_PORTS];

    router_req_t       req_queue [$];
    router_rsp_t       due_responses [$];
    router_req_t       drive_item;
    router_req_t       seen_item;
    router_rsp_t       want_rsp;
    router_rsp_t       got_rsp;
    logic              req_fire;
    int                cycles;
    logic              calm;
    int                failures;
    int                n_arrivals;
    int                n_refused;
    int                n_ticks;
    int                n_forwarded;
    int                port_hits [NUM_PORTS];

    // a long window without any idling on either side
    assign calm = ((cycles % 4000) >= 1500) && ((cycles % 4000) < 2300);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic port_t xy_route(input logic [ID_W-1:0] id,
                                       input logic [FLIT_W-1:0] f);
        int    dest;
        int    ptype;
        int    here_col;
        int    here_row;
        int    dest_col;
        int    dest_row;
        port_t r;
        dest     = f[DEST_LSB +: ID_W];
        ptype    = f[TYPE_LSB +: ID_W];
        here_col = int'(id) % MESH_COLS;
        here_row = int'(id) / MESH_COLS;
        dest_col = dest % MESH_COLS;
        dest_row = dest / MESH_COLS;
        if (id == 0 && dest == 0 && ptype == PTYPE_NODE_RESULT)
            r = PORT_CTRL;
        else if (dest == int'(id))
            r = PORT_LOCAL;
        else if (dest_col > here_col)
            r = PORT_EAST;
        else if (dest_col < here_col)
            r = PORT_WEST;
        else if (dest_row > here_row)
            r = PORT_SOUTH;
        else if (dest_row < here_row)
            r = PORT_NORTH;
        else
            r = PORT_LOCAL;
        return r;
    endfunction

    task automatic fifo_pop(input int p);
        fifo_rd[p]  = (fifo_rd[p] + 1) % FIFO_DEPTH;
        fifo_cnt[p] = fifo_cnt[p] - 1;
    endtask

    task automatic forward_step(input router_req_t rq, output router_rsp_t rs);
        int                o;
        int                p;
        int                src;
        bit                done;
        logic [FLIT_W-1:0] f;
        port_t             dst;
        rs   = '0;
        done = 1'b0;
        if (rq.kind == KIND_ARRIVAL)
        begin
            if (rq.port < NUM_PORTS && fifo_cnt[rq.port] < FIFO_DEPTH)
            begin
                fifo_mem[rq.port][fifo_wr[rq.port]] = rq.flit;
                fifo_wr[rq.port]  = (fifo_wr[rq.port] + 1) % FIFO_DEPTH;
                fifo_cnt[rq.port] = fifo_cnt[rq.port] + 1;
                rs.accepted = 1'b1;
            end
        end
        else
        begin
            // locked outputs drain their owner first, whatever the flit kind
            for (o = 0; o < NUM_PORTS; o++)
            begin
                if (!done && out_locked[o] && fifo_cnt[out_owner[o]] != 0)
                begin
                    src = out_owner[o];
                    f   = fifo_mem[src][fifo_rd[src]];
                    fifo_pop(src);
                    if (f[FKIND_LSB +: 2] == FKIND_TAIL)
                    begin
                        out_locked[o] = 1'b0;
                        out_owner[o]  = 0;
                    end
                    rs.sent = 1'b1;
                    rs.port = PORT_W'(o);
                    rs.flit = f;
                    done    = 1'b1;
                end
            end
            // then a head flit that can claim a free output
            for (p = 0; p < NUM_PORTS; p++)
            begin
                if (!done && fifo_cnt[p] != 0)
                begin
                    f = fifo_mem[p][fifo_rd[p]];
                    if (f[FKIND_LSB +: 2] == FKIND_HEAD)
                    begin
                        dst = xy_route(node_id, f);
                        if (!out_locked[dst])
                        begin
                            out_locked[dst] = 1'b1;
                            out_owner[dst]  = p;
                            fifo_pop(p);
                            rs.sent = 1'b1;
                            rs.port = dst;
                            rs.flit = f;
                            done    = 1'b1;
                        end
                    end
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [FLIT_W-1:0] want_v,
                               input logic [FLIT_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %h, actual %h", name, want_v, got_v);
            failures++;
        end
    endtask

    // request side: sample the transaction and predict its response
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                req_fire = 1'b1;
                seen_item.kind = req_ch.kind;
                seen_item.port = req_ch.arrival_port;
                seen_item.flit = req_ch.arriving_flit;
                forward_step(seen_item, want_rsp);
                due_responses.push_back(want_rsp);
                if (seen_item.kind == KIND_ARRIVAL)
                begin
                    n_arrivals++;
                    if (!want_rsp.accepted)
                        n_refused++;
                end
                else
                begin
                    n_ticks++;
                    if (want_rsp.sent)
                    begin
                        n_forwarded++;
                        port_hits[want_rsp.port]++;
                    end
                end
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got_rsp.accepted = rsp_ch.accepted;
                got_rsp.sent     = rsp_ch.sent;
                got_rsp.port     = rsp_ch.send_port;
                got_rsp.flit     = rsp_ch.sent_flit;
                if (due_responses.size() == 0)
                begin
                    $error("response with nothing pending: accepted %0d sent %0d port %0d flit %h",
                           got_rsp.accepted, got_rsp.sent, got_rsp.port, got_rsp.flit);
                    failures++;
                end
                else
                begin
                    want_rsp = due_responses.pop_front();
                    check_field("accepted", want_rsp.accepted, got_rsp.accepted);
                    check_field("sent", want_rsp.sent, got_rsp.sent);
                    check_field("send_port", want_rsp.port, got_rsp.port);
                    check_field("sent_flit", want_rsp.flit, got_rsp.flit);
                end
            end
        end
    end

    // drive inputs on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_ch.valid || req_fire)
            begin
                req_fire = 1'b0;
                if (req_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    drive_item = req_queue.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.kind          <= drive_item.kind;
                    req_ch.arrival_port  <= drive_item.port;
                    req_ch.arriving_flit <= drive_item.flit;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("wormhole_xy_mesh_router test failed");
            $finish;
        end
    end

    function automatic logic [FLIT_W-1:0] build_flit(input logic [1:0] fk,
                                                     input logic [ID_W-1:0] dest,
                                                     input logic [ID_W-1:0] ptype);
        logic [31:0] payload;
        payload = $urandom();
        return {fk, dest, ptype, payload[23:0]};
    endfunction

    function automatic logic [FLIT_W-1:0] rand_flit();
        logic [1:0] fk;
        fk = 2'($urandom_range(0, 3));
        return {fk, 32'($urandom())};
    endfunction

    task automatic queue_item(input logic k, input logic [PORT_W-1:0] p,
                              input logic [FLIT_W-1:0] f);
        router_req_t it;
        it.kind = k;
        it.port = p;
        it.flit = f;
        while (req_queue.size() >= 2)
            @(negedge clk);
        req_queue.push_back(it);
    endtask

    // port and flit lines carry random junk on a tick
    task automatic queue_tick();
        queue_item(KIND_TICK, PORT_W'($urandom()), rand_flit());
    endtask

    task automatic packet_flit(input int p);
        int              r;
        logic [ID_W-1:0] dest;
        logic [ID_W-1:0] ptype;
        if (pkt_left[p] == 0)
        begin
            r     = $urandom_range(0, 99);
            ptype = ID_W'($urandom());
            if (r < 15)
                dest = node_id;
            else if (r < 30)
            begin
                dest  = '0;
                ptype = PTYPE_NODE_RESULT;
            end
            else
                dest = ID_W'($urandom());
            pkt_left[p] = $urandom_range(1, 5);
            queue_item(KIND_ARRIVAL, PORT_W'(p), build_flit(FKIND_HEAD, dest, ptype));
        end
        else
        begin
            pkt_left[p]--;
            queue_item(KIND_ARRIVAL, PORT_W'(p),
                       build_flit(pkt_left[p] == 0 ? FKIND_TAIL : FKIND_BODY,
                                  ID_W'($urandom()), ID_W'($urandom())));
        end
    endtask

    // noise_pct of the arrivals are raw flits that break packets and overflow fifos
    task automatic random_phase(input int n_items, input int noise_pct);
        int k;
        int p;
        int r;
        for (k = 0; k < n_items; k++)
        begin
            if ($urandom_range(0, 99) < 2)
                queue_item(KIND_ARRIVAL, PORT_W'($urandom_range(6, 7)), rand_flit());
            r = $urandom_range(0, 99);
            p = $urandom_range(0, NUM_PORTS - 1);
            if (r < 45)
                queue_tick();
            else if ($urandom_range(0, 99) < noise_pct)
                queue_item(KIND_ARRIVAL, PORT_W'(p), rand_flit());
            else if (fifo_cnt[p] > FIFO_DEPTH - 4)
                queue_tick();
            else
                packet_flit(p);
        end
    endtask

    task automatic wait_idle();
        while (req_queue.size() != 0 || req_ch.valid || due_responses.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_router_id(input logic [ID_W-1:0] id);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= id;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        node_id = id;
    endtask

    function automatic bit fabric_busy();
        int p;
        bit busy;
        busy = 1'b0;
        for (p = 0; p < NUM_PORTS; p++)
            if (pkt_left[p] != 0 || fifo_cnt[p] != 0)
                busy = 1'b1;
        return busy;
    endfunction

    // finish every open packet and tick until all fifos are empty
    task automatic drain_fabric();
        int guard;
        int p;
        int pick;
        guard = 0;
        do
        begin
            while (fabric_busy() && guard < 1500)
            begin
                pick = -1;
                for (p = 0; p < NUM_PORTS; p++)
                    if (pick < 0 && pkt_left[p] != 0 && fifo_cnt[p] <= FIFO_DEPTH - 4)
                        pick = p;
                if (pick >= 0 && $urandom_range(0, 1) == 1)
                    packet_flit(pick);
                else
                    queue_tick();
                guard++;
            end
            wait_idle();
        end
        while (fabric_busy() && guard < 1500);
    endtask

    initial
    begin
        int k;
        int p;
        logic [ID_W-1:0] id_list [5];

        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = '0;
        req_ch.valid         = 1'b0;
        req_ch.kind          = KIND_ARRIVAL;
        req_ch.arrival_port  = '0;
        req_ch.arriving_flit = '0;
        rsp_ch.ready         = 1'b0;
        req_fire             = 1'b0;
        cycles               = 0;
        failures             = 0;
        n_arrivals           = 0;
        n_refused            = 0;
        n_ticks              = 0;
        n_forwarded          = 0;
        node_id              = '0;
        for (p = 0; p < NUM_PORTS; p++)
        begin
            fifo_rd[p]    = 0;
            fifo_wr[p]    = 0;
            fifo_cnt[p]   = 0;
            out_locked[p] = 1'b0;
            out_owner[p]  = 0;
            pkt_left[p]   = 0;
            port_hits[p]  = 0;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_router_id(4'd0);

        // result packet for router 0 goes to ctrl, then reserved kind and a head
        // ride the locked output, the tail releases it
        queue_item(KIND_ARRIVAL, PORT_LOCAL,
                   {FKIND_HEAD, 4'd0, PTYPE_NODE_RESULT, 24'hffffff});
        queue_tick();
        queue_item(KIND_ARRIVAL, PORT_LOCAL, {FKIND_RSVD, 32'hffffffff});
        queue_tick();
        queue_item(KIND_ARRIVAL, PORT_LOCAL, build_flit(FKIND_HEAD, 4'd9, 4'd2));
        queue_tick();
        queue_item(KIND_ARRIVAL, PORT_LOCAL, {FKIND_TAIL, 32'h00000000});
        queue_tick();
        // arrivals on ports that do not exist
        queue_item(KIND_ARRIVAL, 3'd6, rand_flit());
        queue_item(KIND_ARRIVAL, 3'd7, {2'b11, 32'hffffffff});
        queue_tick();
        // fill the ctrl fifo with head/tail pairs, the next head is dropped
        for (k = 0; k < FIFO_DEPTH / 2; k++)
        begin
            queue_item(KIND_ARRIVAL, PORT_CTRL, build_flit(FKIND_HEAD, ID_W'(k), 4'd0));
            queue_item(KIND_ARRIVAL, PORT_CTRL, build_flit(FKIND_TAIL, 4'hf, 4'hf));
        end
        queue_item(KIND_ARRIVAL, PORT_CTRL, build_flit(FKIND_HEAD, 4'd3, 4'd1));

        random_phase(PHASE_ITEMS, 0);
        id_list = '{4'd15, 4'd6, 4'd9, 4'd3, 4'd12};
        for (k = 0; k < 5; k++)
        begin
            set_router_id(id_list[k]);
            random_phase(PHASE_ITEMS, 0);
        end

        drain_fabric();
        // unlocked body stays at the front of north, the scan moves on to south
        queue_item(KIND_ARRIVAL, PORT_NORTH, build_flit(FKIND_BODY, 4'd1, 4'd1));
        queue_item(KIND_ARRIVAL, PORT_SOUTH, build_flit(FKIND_HEAD, node_id, 4'd7));
        queue_tick();
        queue_item(KIND_ARRIVAL, PORT_SOUTH, build_flit(FKIND_TAIL, 4'd0, 4'd0));
        queue_tick();
        queue_tick();

        set_router_id(ID_W'($urandom_range(1, 14)));
        random_phase(260, 35);

        wait_idle();
        repeat (10) @(negedge clk);
        $display("covered %0d arrivals (%0d not stored) and %0d ticks, %0d flits forwarded",
                 n_arrivals, n_refused, n_ticks, n_forwarded);
        $display("flits per output local %0d north %0d east %0d south %0d west %0d ctrl %0d",
                 port_hits[0], port_hits[1], port_hits[2], port_hits[3], port_hits[4],
                 port_hits[5]);
        if (failures == 0)
            $display("wormhole_xy_mesh_router test passed");
        else
            $display("wormhole_xy_mesh_router test failed");
        $finish;
    end

endmodule
